@@ sv/gregorian_date_add_days_core_macros.svh @@
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core_macros.svh
// Assertion macros for the date-advance checker.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_ADD_DAYS_CORE_MACROS_SVH
`define GREGORIAN_DATE_ADD_DAYS_CORE_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define GDAD_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define GDAD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/gdad_pkg.sv @@
// ----------------------------------------------------------------------------
// gdad_pkg
// Widths, month codes, month-length table and the working-date record.
// ----------------------------------------------------------------------------
package gdad_pkg;

  localparam int DAY_W  = 5;
  localparam int MON_W  = 4;
  localparam int YEAR_W = 16;
  localparam int ADD_W  = 16;
  localparam int ACC_W  = 17;   // day accumulator: 31 + 65535 fits
  localparam int LEN_W  = 5;
  localparam int REM_W  = 7;    // year mod 100
  localparam int CEN_W  = 10;   // year div 100, at most 655

  localparam logic [MON_W-1:0] MON_JAN = 4'd1;
  localparam logic [MON_W-1:0] MON_FEB = 4'd2;
  localparam logic [MON_W-1:0] MON_APR = 4'd4;
  localparam logic [MON_W-1:0] MON_JUN = 4'd6;
  localparam logic [MON_W-1:0] MON_SEP = 4'd9;
  localparam logic [MON_W-1:0] MON_NOV = 4'd11;
  localparam logic [MON_W-1:0] MON_DEC = 4'd12;

  localparam logic [LEN_W-1:0] LEN_SHORT = 5'd28;
  localparam logic [LEN_W-1:0] LEN_MID   = 5'd30;
  localparam logic [LEN_W-1:0] LEN_LONG  = 5'd31;

  localparam logic [REM_W-1:0]  REM_LAST  = 7'd99;
  localparam logic [YEAR_W-1:0] YEAR_LAST = 16'hFFFF;

  // Reciprocal of 100, rounded down: floor(y * 10485 / 2^20) is y/100 or
  // one less for every 16-bit y.
  localparam int RECIP_100   = 10485;
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 14;
  localparam int PROD_W      = YEAR_W + RECIP_W;
  localparam int CENTURY     = 100;

  typedef struct packed {
    logic [ACC_W-1:0]  d;
    logic [MON_W-1:0]  m;
    logic [YEAR_W-1:0] y;
    logic [REM_W-1:0]  r;
    logic [CEN_W-1:0]  q;
    logic              wrapped;
  } gdad_date_t;

  function automatic logic [LEN_W-1:0] base_len(input logic [MON_W-1:0] m);
    logic [LEN_W-1:0] len;
    case (m)
      MON_FEB:                            len = LEN_SHORT;
      MON_APR, MON_JUN, MON_SEP, MON_NOV: len = LEN_MID;
      default:                            len = LEN_LONG;
    endcase
    return len;
  endfunction

endpackage

@@ sv/gdad_yrsplit.sv @@
// ----------------------------------------------------------------------------
// gdad_yrsplit
// Split a year into year/100 and year%100: registered reciprocal multiply,
// then one compare-and-subtract correction.
// ----------------------------------------------------------------------------
module gdad_yrsplit
  import gdad_pkg::*;
(
  input  logic              clk,
  input  logic              load,
  input  logic [YEAR_W-1:0] year,
  output logic [CEN_W-1:0]  cent,
  output logic [REM_W-1:0]  rem
);

  localparam int DIFF_W = YEAR_W + 1;
  localparam int RAW_W  = REM_W + 1;

  logic [PROD_W-1:0] prod;
  logic [YEAR_W-1:0] year_lat;
  logic [CEN_W-1:0]  q_est;
  logic [DIFF_W-1:0] diff;
  logic [RAW_W-1:0]  rem_raw;

  always_ff @(posedge clk) begin
    if (load) begin
      prod     <= PROD_W'(year) * PROD_W'(RECIP_100);
      year_lat <= year;
    end
  end

  always_comb begin
    q_est   = prod[RECIP_SHIFT +: CEN_W];
    diff    = DIFF_W'(year_lat) - DIFF_W'(q_est) * DIFF_W'(CENTURY);
    rem_raw = diff[RAW_W-1:0];
    // Estimate may be one low: fold back once.
    if (rem_raw >= RAW_W'(CENTURY)) begin
      rem  = REM_W'(rem_raw - RAW_W'(CENTURY));
      cent = q_est + CEN_W'(1);
    end else begin
      rem  = rem_raw[REM_W-1:0];
      cent = q_est;
    end
  end

endmodule

@@ sv/gdad_step.sv @@
// ----------------------------------------------------------------------------
// gdad_step
// One month step: month length with leap rule, compare, subtract, advance.
// ----------------------------------------------------------------------------
module gdad_step
  import gdad_pkg::*;
(
  input  gdad_date_t cur,
  output gdad_date_t nxt,
  output logic       more
);

  logic             leap;
  logic [LEN_W-1:0] len;

  always_comb begin
    // Century years are leap only when the century count is a multiple of 4.
    leap = (cur.r == '0) ? (cur.q[1:0] == 2'd0) : (cur.y[1:0] == 2'd0);
    len  = base_len(cur.m) + LEN_W'((cur.m == MON_FEB) && leap);
    more = cur.d > ACC_W'(len);

    nxt   = cur;
    nxt.d = cur.d - ACC_W'(len);
    if (cur.m == MON_DEC) begin
      nxt.m = MON_JAN;
      nxt.y = cur.y + YEAR_W'(1);
      if (cur.y == YEAR_LAST) begin
        nxt.r       = '0;
        nxt.q       = '0;
        nxt.wrapped = 1'b1;
      end else if (cur.r == REM_LAST) begin
        nxt.r = '0;
        nxt.q = cur.q + CEN_W'(1);
      end else begin
        nxt.r = cur.r + REM_W'(1);
      end
    end else begin
      nxt.m = cur.m + MON_W'(1);
    end
  end

endmodule

@@ sv/gregorian_date_add_days_core.sv @@
// Sequence: accept, year split, then N month steps, N at most about 2155 for
// a 16-bit day count; the hand-off to the output register waits while it is held.
// Throughput: one item at a time; in_ready is low from accept until the
// result is loaded into the output register. A bad month skips the year split.
// Reset: synchronous, active high; clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// gregorian_date_add_days_core
// Advance a Gregorian date by a day count, one month per clock.
// ----------------------------------------------------------------------------
module gregorian_date_add_days_core
  import gdad_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [DAY_W-1:0]  start_day,
  input  logic [MON_W-1:0]  start_month,
  input  logic [YEAR_W-1:0] start_year,
  input  logic [ADD_W-1:0]  days_to_add,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DAY_W-1:0]  result_day,
  output logic [MON_W-1:0]  result_month,
  output logic [YEAR_W-1:0] result_year,
  output logic              year_wrapped,
  output logic              bad_month
);

  // Sequencer: IDLE takes an item, SPLIT loads year/100 and year%100,
  // RUN steps one month per cycle and hands off to the output register.
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SPLIT = 2'd1;
  localparam logic [1:0] S_RUN   = 2'd2;

  logic [1:0]       state;
  gdad_date_t       date;
  gdad_date_t       date_next;
  logic             bad;
  logic             more;
  logic             accept;
  logic             month_bad;
  logic             finish;
  logic [CEN_W-1:0] split_cent;
  logic [REM_W-1:0] split_rem;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign month_bad = (start_month < MON_JAN) || (start_month > MON_DEC);
  // Finish when no more month steps are due and the output register is free.
  assign finish    = (state == S_RUN) && !(more && !bad) && (!out_valid || out_ready);

  gdad_yrsplit u_yrsplit (
    .clk  (clk),
    .load (accept),
    .year (start_year),
    .cent (split_cent),
    .rem  (split_rem)
  );

  // The shared step unit: month length, compare, subtract, advance.
  gdad_step u_step (
    .cur  (date),
    .nxt  (date_next),
    .more (more)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          // A bad month skips the year split and passes straight through.
          if (accept) state <= month_bad ? S_RUN : S_SPLIT;
        end
        S_SPLIT: begin
          state <= S_RUN;
        end
        S_RUN: begin
          if (finish) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Working date: load on accept, take split results, then step.
  always_ff @(posedge clk) begin
    if (accept) begin
      date.d       <= month_bad ? ACC_W'(start_day)
                                : ACC_W'(start_day) + ACC_W'(days_to_add);
      date.m       <= start_month;
      date.y       <= start_year;
      date.r       <= '0;
      date.q       <= '0;
      date.wrapped <= 1'b0;
      bad          <= month_bad;
    end else if (state == S_SPLIT) begin
      date.r <= split_rem;
      date.q <= split_cent;
    end else if ((state == S_RUN) && more && !bad) begin
      date <= date_next;
    end
  end

  // Output register: holds the item until the sink takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      result_day   <= date.d[DAY_W-1:0];
      result_month <= date.m;
      result_year  <= date.y;
      year_wrapped <= date.wrapped;
      bad_month    <= bad;
    end
  end

endmodule

@@ sv/gdad_checker.sv @@
// ----------------------------------------------------------------------------
// gdad_checker
// Port-level checks for the date-advance core, bound to the top level.
// ----------------------------------------------------------------------------
`include "gregorian_date_add_days_core_macros.svh"

module gdad_checker
  import gdad_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [DAY_W-1:0]  result_day,
  input logic [MON_W-1:0]  result_month,
  input logic [YEAR_W-1:0] result_year,
  input logic              year_wrapped,
  input logic              bad_month
);

  // A held result stays put until taken.
  `GDAD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable({result_day, result_month, result_year, year_wrapped, bad_month}), "output item changed while stalled")

  // One item at a time: busy right after an accept.
  `GDAD_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "input ready right after accept")

  // Advanced dates always land on a real month.
  `GDAD_ASSERT_NOW(a_month_range, clk, rst, out_valid && !bad_month, (result_month >= MON_JAN) && (result_month <= MON_DEC), "result month out of range")

  // Pass-through items never report a year wrap.
  `GDAD_ASSERT_NOW(a_bad_no_wrap, clk, rst, out_valid && bad_month, !year_wrapped, "year wrap flagged on bad month")

endmodule

bind gregorian_date_add_days_core gdad_checker u_gdad_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .result_day   (result_day),
  .result_month (result_month),
  .result_year  (result_year),
  .year_wrapped (year_wrapped),
  .bad_month    (bad_month)
);
